// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/pitb_pkg.sv =====
// Package: widths, types and verdict codes of the point-in-triangle block.
`timescale 1ns / 1ps

package pitb_pkg;

    // Coordinate width; the legal range is 8 to 32.
    localparam int COORD_WIDTH = 16;

    // Edge and offset vectors: one bit over the coordinates.
    localparam int EW = COORD_WIDTH + 1;
    // One product of two vector components.
    localparam int SW = 2 * EW;
    // Dot product of two vectors (sum of three products).
    localparam int DW = SW + 1;
    // Split of a dot product for the wide multiplier.
    localparam int LO_W = DW / 2;
    localparam int HI_W = DW - LO_W;
    // Product of two dot products.
    localparam int PW = 2 * DW;
    // det, un, vn and det - un - vn.
    localparam int WW = PW + 2;

    localparam int VERDICT_W = 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [EW-1:0]          t_diff;
    typedef logic signed [SW-1:0]          t_sprod;
    typedef logic signed [DW-1:0]          t_dot;
    typedef logic signed [PW-1:0]          t_wprod;
    typedef logic signed [WW-1:0]          t_wide;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_INSIDE     = 3'd0,
        VERDICT_DEGENERATE = 3'd1,
        VERDICT_U_NEG      = 3'd2,
        VERDICT_V_NEG      = 3'd3,
        VERDICT_UV_OVER    = 3'd4
    } t_verdict;

    typedef struct packed {
        logic     in_tri;
        t_verdict verdict;
    } t_result;

endpackage

// ===== rtl/pitb_wmul.sv =====
// Two-stage signed multiplier for dot-product words, built from four partial products.
`timescale 1ns / 1ps

module pitb_wmul
    import pitb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_dot   i_a,
    input  t_dot   i_b,
    output t_wprod o_p
);

    logic signed [HI_W-1:0] a_hi, b_hi;
    logic        [LO_W-1:0] a_lo, b_lo;

    assign a_hi = i_a[DW-1:LO_W];
    assign b_hi = i_b[DW-1:LO_W];
    assign a_lo = i_a[LO_W-1:0];
    assign b_lo = i_b[LO_W-1:0];

    logic signed [2*HI_W-1:0] r_hh;
    logic signed [DW:0]       r_hl, r_lh;
    logic        [2*LO_W-1:0] r_ll;
    t_wprod                   n_p, r_p;

    // stage A: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= a_hi * b_hi;
            r_hl <= a_hi * $signed({1'b0, b_lo});
            r_lh <= $signed({1'b0, a_lo}) * b_hi;
            r_ll <= a_lo * b_lo;
        end
    end

    // stage B: weighted sum; exact, so modulo 2^PW arithmetic is safe
    always_comb begin
        n_p = (t_wprod'(r_hh) <<< (2 * LO_W))
            + (t_wprod'(r_hl) <<< LO_W)
            + (t_wprod'(r_lh) <<< LO_W)
            + t_wprod'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/point_in_triangle_barycentric.sv =====
// Top level: pipelined barycentric point-in-triangle test.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one word per clock: triangle vertices A, B, C and a query point P as
// signed COORD_WIDTH-bit coordinates, and returns one result word per input
// word, in order: o_inside_res (1 when P is inside or on the triangle) and
// o_verdict (0 inside, 1 degenerate, 2 u negative, 3 v negative, 4 u+v over
// one; the first failing check wins). The test is exact: edge vectors,
// the five dot products and det/un/vn are carried at full width, with no
// division. Throughput is one word per cycle while the skid entry is free;
// the word passes seven register stages (differences, loaded at the accept
// edge itself, component products, dot-product sums, two wide-multiplier
// stages, det/un/vn, verdict into the output register). A two-entry
// output buffer (output register plus skid) decouples the sides, so
// o_in_ready is a register and only drops while the skid entry is occupied.
// ignore_height, written through the cfg channel (always ready), zeroes
// every y difference for the x-z test; write it only while the block is
// empty.

module point_in_triangle_barycentric
    import pitb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,

    input  logic   i_cfg_valid,
    output logic   o_cfg_ready,
    input  logic   i_cfg_ignore_height,

    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_coord i_a_x,
    input  t_coord i_a_y,
    input  t_coord i_a_z,
    input  t_coord i_b_x,
    input  t_coord i_b_y,
    input  t_coord i_b_z,
    input  t_coord i_c_x,
    input  t_coord i_c_y,
    input  t_coord i_c_z,
    input  t_coord i_p_x,
    input  t_coord i_p_y,
    input  t_coord i_p_z,

    output logic   o_out_valid,
    input  logic   i_out_ready,
    output logic   o_inside_res,
    output logic [VERDICT_W-1:0] o_verdict
);

    // ---------------------------------------------------------------
    // Config register
    // ---------------------------------------------------------------
    logic r_ignore_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_height <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ignore_height <= i_cfg_ignore_height;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: every stage moves together while the skid
    // entry is free, so nothing in flight can be dropped.
    // ---------------------------------------------------------------
    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic r_hd_v, r_sk_v;

    assign en         = !r_sk_v;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: e0 = B - A, e1 = C - A, w = P - A
    // ---------------------------------------------------------------
    t_coord s_a [3];
    t_coord s_b [3];
    t_coord s_c [3];
    t_coord s_p [3];

    assign s_a[0] = i_a_x;
    assign s_a[1] = i_a_y;
    assign s_a[2] = i_a_z;
    assign s_b[0] = i_b_x;
    assign s_b[1] = i_b_y;
    assign s_b[2] = i_b_z;
    assign s_c[0] = i_c_x;
    assign s_c[1] = i_c_y;
    assign s_c[2] = i_c_z;
    assign s_p[0] = i_p_x;
    assign s_p[1] = i_p_y;
    assign s_p[2] = i_p_z;

    t_diff n_e0 [3];
    t_diff n_e1 [3];
    t_diff n_w  [3];
    t_diff r_e0 [3];
    t_diff r_e1 [3];
    t_diff r_w  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_e0[k] = t_diff'(s_b[k]) - t_diff'(s_a[k]);
            n_e1[k] = t_diff'(s_c[k]) - t_diff'(s_a[k]);
            n_w[k]  = t_diff'(s_p[k]) - t_diff'(s_a[k]);
        end
        // x-z projection: drop the height axis
        if (r_ignore_height) begin
            n_e0[1] = '0;
            n_e1[1] = '0;
            n_w[1]  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e0 <= n_e0;
            r_e1 <= n_e1;
            r_w  <= n_w;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: component products of the five dot products
    // ---------------------------------------------------------------
    t_sprod r_m00 [3];
    t_sprod r_m01 [3];
    t_sprod r_m02 [3];
    t_sprod r_m11 [3];
    t_sprod r_m12 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m00[k] <= r_e0[k] * r_e0[k];
                r_m01[k] <= r_e0[k] * r_e1[k];
                r_m02[k] <= r_e0[k] * r_w[k];
                r_m11[k] <= r_e1[k] * r_e1[k];
                r_m12[k] <= r_e1[k] * r_w[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: dot-product sums
    // ---------------------------------------------------------------
    t_dot r_d00, r_d01, r_d02, r_d11, r_d12;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d00 <= t_dot'(r_m00[0]) + t_dot'(r_m00[1]) + t_dot'(r_m00[2]);
            r_d01 <= t_dot'(r_m01[0]) + t_dot'(r_m01[1]) + t_dot'(r_m01[2]);
            r_d02 <= t_dot'(r_m02[0]) + t_dot'(r_m02[1]) + t_dot'(r_m02[2]);
            r_d11 <= t_dot'(r_m11[0]) + t_dot'(r_m11[1]) + t_dot'(r_m11[2]);
            r_d12 <= t_dot'(r_m12[0]) + t_dot'(r_m12[1]) + t_dot'(r_m12[2]);
        end
    end

    // ---------------------------------------------------------------
    // Stages 4-5: six wide products
    // ---------------------------------------------------------------
    t_wprod p_d00d11, p_d01d01, p_d11d02, p_d01d12, p_d00d12, p_d01d02;

    pitb_wmul u_mul_d00d11 (.i_clk(i_clk), .i_en(en), .i_a(r_d00), .i_b(r_d11), .o_p(p_d00d11));
    pitb_wmul u_mul_d01d01 (.i_clk(i_clk), .i_en(en), .i_a(r_d01), .i_b(r_d01), .o_p(p_d01d01));
    pitb_wmul u_mul_d11d02 (.i_clk(i_clk), .i_en(en), .i_a(r_d11), .i_b(r_d02), .o_p(p_d11d02));
    pitb_wmul u_mul_d01d12 (.i_clk(i_clk), .i_en(en), .i_a(r_d01), .i_b(r_d12), .o_p(p_d01d12));
    pitb_wmul u_mul_d00d12 (.i_clk(i_clk), .i_en(en), .i_a(r_d00), .i_b(r_d12), .o_p(p_d00d12));
    pitb_wmul u_mul_d01d02 (.i_clk(i_clk), .i_en(en), .i_a(r_d01), .i_b(r_d02), .o_p(p_d01d02));

    // ---------------------------------------------------------------
    // Stage 6: det, un, vn
    // ---------------------------------------------------------------
    t_wide r_det, r_un, r_vn;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= t_wide'(p_d00d11) - t_wide'(p_d01d01);
            r_un  <= t_wide'(p_d11d02) - t_wide'(p_d01d12);
            r_vn  <= t_wide'(p_d00d12) - t_wide'(p_d01d02);
        end
    end

    // ---------------------------------------------------------------
    // Verdict: checks in priority order, first failure wins.
    // u + v <= 1 is det - un - vn >= 0.
    // ---------------------------------------------------------------
    t_wide   slack;
    t_result n_res;

    assign slack = r_det - r_un - r_vn;

    always_comb begin
        priority if (r_det == '0) begin
            n_res.verdict = VERDICT_DEGENERATE;
        end else if (r_un[WW-1]) begin
            n_res.verdict = VERDICT_U_NEG;
        end else if (r_vn[WW-1]) begin
            n_res.verdict = VERDICT_V_NEG;
        end else if (slack[WW-1]) begin
            n_res.verdict = VERDICT_UV_OVER;
        end else begin
            n_res.verdict = VERDICT_INSIDE;
        end
        n_res.in_tri = (n_res.verdict == VERDICT_INSIDE);
    end

    // ---------------------------------------------------------------
    // Output buffer: head drives the ports, skid catches the word that
    // arrives while the head is stalled.
    // ---------------------------------------------------------------
    t_result r_hd, r_sk;
    logic    push, pop;

    assign push = en && r_v6;
    assign pop  = r_hd_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_v <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            // pipe is frozen, no push possible
            if (pop) begin
                r_hd_v <= 1'b1;
                r_sk_v <= 1'b0;
            end
        end else if (push) begin
            if (r_hd_v && !pop) begin
                r_sk_v <= 1'b1;
            end
            r_hd_v <= 1'b1;
        end else if (pop) begin
            r_hd_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (pop) begin
                r_hd <= r_sk;
            end
        end else if (push) begin
            if (r_hd_v && !pop) begin
                r_sk <= n_res;
            end else begin
                r_hd <= n_res;
            end
        end
    end

    assign o_out_valid  = r_hd_v;
    assign o_inside_res = r_hd.in_tri;
    assign o_verdict    = r_hd.verdict;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_NEVER(a_skid_without_head, r_sk_v && !r_hd_v, "skid word held with empty head")
    `ASSERT_NEVER(a_push_into_full, r_sk_v && push, "word pushed while output buffer full")
    `ASSERT_CLK(a_inside_matches,
        o_out_valid |-> (o_inside_res == (o_verdict == VERDICT_INSIDE)),
        "inside flag disagrees with verdict")

endmodule

// ===== sim/tb_point_in_triangle_barycentric.sv =====
// Testbench for the barycentric point-in-triangle block: directed table plus random words.
`timescale 1ns / 1ps

// Self-checking bench. Every accepted input word gets an expected result from a
// local exact predictor, or from the table where the answer is obvious. The
// expected results sit in a FIFO. Each accepted output word is compared against
// the oldest entry. Both sides idle at random, with stretches at full rate. The
// mode register is only written with the pipe drained.
module tb_point_in_triangle_barycentric;
    import pitb_pkg::*;

    localparam int PIPE_LATENCY   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WORDS_PER_PHASE = 240;
    localparam int RANDOM_PHASES   = 6;
    localparam int COORD_MAX = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int COORD_MIN = -COORD_MAX - 1;

    // 256 bits holds det/un/vn exactly over the whole coordinate width range.
    typedef logic signed [255:0] t_acc;
    // Order of the coordinates: a_x a_y a_z b_x b_y b_z c_x c_y c_z p_x p_y p_z.
    typedef logic [11:0][COORD_WIDTH-1:0] t_coords;

    typedef struct {
        logic     drop_y;
        t_coords  coords;
        bit       known;
        t_verdict verdict;
    } t_directed_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_cfg_valid = 1'b0;
    logic    i_cfg_ignore_height = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    i_out_ready = 1'b0;
    t_coords in_coords = '0;
    logic    o_cfg_ready;
    logic    o_in_ready;
    logic    o_out_valid;
    logic    o_inside_res;
    logic [VERDICT_W-1:0] o_verdict;

    // Typed expectation for the word currently offered; ignored when row_known is low.
    bit       row_known = 1'b0;
    t_verdict row_verdict = VERDICT_INSIDE;

    t_result       expected_verdicts [$];
    t_directed_row directed_rows [$];
    logic          height_dropped = 1'b0;   // predictor copy of ignore_height
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            send_run = 0;
    int            sink_run = 0;

    point_in_triangle_barycentric DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_ignore_height (i_cfg_ignore_height),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_a_x               (in_coords[0]),
        .i_a_y               (in_coords[1]),
        .i_a_z               (in_coords[2]),
        .i_b_x               (in_coords[3]),
        .i_b_y               (in_coords[4]),
        .i_b_z               (in_coords[5]),
        .i_c_x               (in_coords[6]),
        .i_c_y               (in_coords[7]),
        .i_c_z               (in_coords[8]),
        .i_p_x               (in_coords[9]),
        .i_p_y               (in_coords[10]),
        .i_p_z               (in_coords[11]),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_inside_res        (o_inside_res),
        .o_verdict           (o_verdict)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Exact barycentric test on the numerators; checks run in the block's order,
    // first failure wins.
    function automatic t_result predict_containment(t_coords w, logic drop_y);
        t_acc    e0 [3];
        t_acc    e1 [3];
        t_acc    ofs [3];
        t_acc    base, d00, d01, d02, d11, d12, det, un, vn;
        t_result r;
        for (int k = 0; k < 3; k++) begin
            base   = $signed(w[k]);
            e0[k]  = $signed(w[3 + k]) - base;
            e1[k]  = $signed(w[6 + k]) - base;
            ofs[k] = $signed(w[9 + k]) - base;
        end
        if (drop_y) begin
            e0[1]  = '0;
            e1[1]  = '0;
            ofs[1] = '0;
        end
        d00 = e0[0] * e0[0]  + e0[1] * e0[1]  + e0[2] * e0[2];
        d01 = e0[0] * e1[0]  + e0[1] * e1[1]  + e0[2] * e1[2];
        d02 = e0[0] * ofs[0] + e0[1] * ofs[1] + e0[2] * ofs[2];
        d11 = e1[0] * e1[0]  + e1[1] * e1[1]  + e1[2] * e1[2];
        d12 = e1[0] * ofs[0] + e1[1] * ofs[1] + e1[2] * ofs[2];
        det = d00 * d11 - d01 * d01;
        un  = d11 * d02 - d01 * d12;
        vn  = d00 * d12 - d01 * d02;
        r.in_tri = 1'b0;
        if (det == 0)
            r.verdict = VERDICT_DEGENERATE;
        else if (un < 0)
            r.verdict = VERDICT_U_NEG;
        else if (vn < 0)
            r.verdict = VERDICT_V_NEG;
        else if (det - un - vn < 0)
            r.verdict = VERDICT_UV_OVER;
        else begin
            r.verdict = VERDICT_INSIDE;
            r.in_tri  = 1'b1;
        end
        return r;
    endfunction

    function automatic int clamp_coord(int x);
        if (x < COORD_MIN) return COORD_MIN;
        if (x > COORD_MAX) return COORD_MAX;
        return x;
    endfunction

    function automatic int pick_coord(int span);
        return clamp_coord(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Idle cycles before the next word; now and then a run of back-to-back words.
    function automatic int draw_idle(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            run_left = $urandom_range(8, 40);
        return $urandom_range(0, 10);
    endfunction

    // Mostly real triangles with P built from barycentric weights (inside, on the
    // border or beyond it); the rest degenerate, extreme or raw noise.
    function automatic t_coords make_triangle_word(logic drop_y);
        t_coords w;
        int      vtx [9];
        int      kind, span, den, wa, wb, wc, m;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0, 1:    span = 100;
            2:       span = 4000;
            default: span = COORD_MAX + 1;
        endcase
        if (kind < 10) begin
            for (int k = 0; k < 12; k++) w[k] = COORD_WIDTH'($urandom);
            return w;
        end
        if (kind < 18) begin
            for (int k = 0; k < 12; k++) begin
                case ($urandom_range(0, 6))
                    0:       w[k] = COORD_WIDTH'(COORD_MIN);
                    1:       w[k] = COORD_WIDTH'(COORD_MIN + 1);
                    2:       w[k] = COORD_WIDTH'(-1);
                    3:       w[k] = COORD_WIDTH'(0);
                    4:       w[k] = COORD_WIDTH'(1);
                    5:       w[k] = COORD_WIDTH'(COORD_MAX - 1);
                    default: w[k] = COORD_WIDTH'(COORD_MAX);
                endcase
            end
            return w;
        end
        for (int k = 0; k < 9; k++) vtx[k] = pick_coord(span);
        if (kind < 28) begin
            // C on the line through A and B (C == A when m is 0)
            m = int'($urandom_range(0, 3)) - 1;
            for (int k = 0; k < 3; k++)
                vtx[6 + k] = clamp_coord(vtx[k] + m * (vtx[3 + k] - vtx[k]));
        end
        den = $urandom_range(1, 64);
        if (kind < 70) begin
            wb = $urandom_range(0, den);
            wc = $urandom_range(0, den - wb);
        end else begin
            wb = int'($urandom_range(0, 2 * den)) - den / 2;
            wc = int'($urandom_range(0, 2 * den)) - den / 2;
        end
        wa = den - wb - wc;
        for (int k = 0; k < 3; k++) begin
            w[9 + k] = COORD_WIDTH'(clamp_coord(
                           (wa * vtx[k] + wb * vtx[3 + k] + wc * vtx[6 + k]) / den
                           + ((kind >= 60 && kind < 70) ?
                              int'($urandom_range(0, 2)) - 1 : 0)));
        end
        for (int k = 0; k < 9; k++) w[k] = COORD_WIDTH'(vtx[k]);
        // heights are don't-care in x-z mode: scramble them half the time
        if (drop_y && $urandom_range(0, 1)) begin
            w[1]  = COORD_WIDTH'($urandom);
            w[4]  = COORD_WIDTH'($urandom);
            w[7]  = COORD_WIDTH'($urandom);
            w[10] = COORD_WIDTH'($urandom);
        end
        return w;
    endfunction

    function automatic void add_row(logic drop_y, int ax, int ay, int az, int bx, int by,
                                    int bz, int cx, int cy, int cz, int px, int py, int pz,
                                    bit known, t_verdict v);
        t_directed_row r;
        int            vals [12];
        vals = '{ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz};
        for (int k = 0; k < 12; k++) r.coords[k] = COORD_WIDTH'(vals[k]);
        r.drop_y  = drop_y;
        r.known   = known;
        r.verdict = v;
        directed_rows.push_back(r);
    endfunction

    // Offer one word; called and returns at a falling edge. Valid stays high
    // across back-to-back words.
    task automatic drive_word(t_coords w, bit known, t_verdict v);
        int gap;
        gap = draw_idle(send_run);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_coords   <= w;
        row_known   <= known;
        row_verdict <= v;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Stop sending, wait for every expected word, then let the pipe settle.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_height_mode(logic drop_y);
        i_cfg_valid         <= 1'b1;
        i_cfg_ignore_height <= drop_y;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Scoreboard and watchdog, all sampled on the rising edge.
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                height_dropped = i_cfg_ignore_height;
            if (i_in_valid && o_in_ready) begin
                if (row_known) begin
                    want.in_tri  = (row_verdict == VERDICT_INSIDE);
                    want.verdict = row_verdict;
                end else begin
                    want = predict_containment(in_coords, height_dropped);
                end
                expected_verdicts.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_inside_res !== want.in_tri) begin
                        $error("inside_res: expected %0d, got %0d", want.in_tri, o_inside_res);
                        mismatch_count++;
                    end
                    if (o_verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
                        mismatch_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_point_in_triangle_barycentric NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stall before each word, sometimes runs at full rate.
    initial begin : result_sink
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_idle(sink_run);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_directed_row row;
        logic          applied_mode;

        // Reference triangle A(0,0,0) B(10,0,0) C(0,0,10) in the y = 0 plane.
        add_row(1'b0, 0, 0, 0,  10, 0, 0,  0, 0, 10,  2, 0, 2,  1'b1, VERDICT_INSIDE);
        add_row(1'b0, 0, 0, 0,  10, 0, 0,  0, 0, 10,  0, 0, 0,  1'b1, VERDICT_INSIDE);
        add_row(1'b0, 0, 0, 0,  10, 0, 0,  0, 0, 10,  5, 0, 5,  1'b1, VERDICT_INSIDE);
        add_row(1'b0, 0, 0, 0,  10, 0, 0,  0, 0, 10, -1, 0, 2,  1'b1, VERDICT_U_NEG);
        add_row(1'b0, 0, 0, 0,  10, 0, 0,  0, 0, 10,  2, 0, -1, 1'b1, VERDICT_V_NEG);
        add_row(1'b0, 0, 0, 0,  10, 0, 0,  0, 0, 10,  6, 0, 6,  1'b1, VERDICT_UV_OVER);
        // P above the plane: projected onto it, so still inside
        add_row(1'b0, 0, 0, 0,  10, 0, 0,  0, 0, 10,  2, 50, 2, 1'b1, VERDICT_INSIDE);
        // degenerate: all points equal, collinear, rails
        add_row(1'b0, 0, 0, 0,  0, 0, 0,  0, 0, 0,  0, 0, 0,  1'b1, VERDICT_DEGENERATE);
        add_row(1'b0, 0, 0, 0,  1, 1, 1,  2, 2, 2,  1, 1, 1,  1'b1, VERDICT_DEGENERATE);
        add_row(1'b0, COORD_MAX, COORD_MAX, COORD_MAX,  COORD_MAX, COORD_MAX, COORD_MAX,
                COORD_MAX, COORD_MAX, COORD_MAX,  COORD_MAX, COORD_MAX, COORD_MAX,
                1'b1, VERDICT_DEGENERATE);
        add_row(1'b0, COORD_MIN, COORD_MIN, COORD_MIN,  COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MIN, COORD_MIN, COORD_MIN,  COORD_MIN, COORD_MIN, COORD_MIN,
                1'b1, VERDICT_DEGENERATE);
        // upright triangle in the x-y plane
        add_row(1'b0, 0, 0, 0,  10, 0, 0,  0, 10, 0,  2, 2, 0,  1'b1, VERDICT_INSIDE);
        // full-scale edges and alternating bit patterns
        add_row(1'b0, COORD_MIN, COORD_MIN, COORD_MIN,  COORD_MAX, COORD_MIN, COORD_MIN,
                COORD_MIN, COORD_MIN, COORD_MAX,  0, COORD_MIN, 0,  1'b0, VERDICT_INSIDE);
        add_row(1'b0, COORD_MAX, COORD_MIN, COORD_MAX,  COORD_MIN, COORD_MAX, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MIN,  COORD_MIN, COORD_MIN, COORD_MAX,
                1'b0, VERDICT_INSIDE);
        add_row(1'b0, 21845, -21846, 21845,  -21846, 21845, -21846,  21845, 21845, -21846,
                -21846, -21846, 21845,  1'b0, VERDICT_INSIDE);
        // x-z mode: the upright triangle collapses
        add_row(1'b1, 0, 0, 0,  10, 0, 0,  0, 10, 0,  2, 2, 0,  1'b1, VERDICT_DEGENERATE);
        add_row(1'b1, 0, 0, 0,  10, 7, 0,  0, -3, 10,  2, 999, 2,  1'b1, VERDICT_INSIDE);
        add_row(1'b1, 0, 5, 0,  10, -5, 0,  0, 9, 10,  -1, 0, 2,  1'b1, VERDICT_U_NEG);
        add_row(1'b1, 0, 5, 0,  10, -5, 0,  0, 9, 10,  2, -7, -1,  1'b1, VERDICT_V_NEG);
        add_row(1'b1, 0, 5, 0,  10, -5, 0,  0, 9, 10,  6, COORD_MIN, 6,
                1'b1, VERDICT_UV_OVER);
        // P on vertex A in x-z, heights wild
        add_row(1'b1, COORD_MIN, COORD_MAX, COORD_MIN,  COORD_MAX, 0, COORD_MIN,
                COORD_MIN, -1, COORD_MAX,  COORD_MIN, 12, COORD_MIN,  1'b1, VERDICT_INSIDE);
        add_row(1'b1, 21845, -21846, 21845,  -21846, 21845, -21846,  21845, 21845, -21846,
                -21846, -21846, 21845,  1'b0, VERDICT_INSIDE);
        add_row(1'b1, COORD_MAX, COORD_MIN, COORD_MAX,  COORD_MIN, COORD_MAX, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MIN,  COORD_MIN, COORD_MIN, COORD_MAX,
                1'b0, VERDICT_INSIDE);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first rows run on the reset value of ignore_height
        applied_mode = 1'b0;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.drop_y != applied_mode) begin
                drain_pipeline();
                write_height_mode(row.drop_y);
                applied_mode = row.drop_y;
            end
            drive_word(row.coords, row.known, row.verdict);
        end

        // random phases alternate the mode; each boundary drains the pipe first
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            applied_mode = (phase % 2 == 1);
            drain_pipeline();
            write_height_mode(applied_mode);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                drive_word(make_triangle_word(applied_mode), 1'b0, VERDICT_INSIDE);
        end

        drain_pipeline();
        if (mismatch_count == 0)
            $display("tb_point_in_triangle_barycentric OK");
        else
            $display("tb_point_in_triangle_barycentric NOT OK");
        $finish;
    end

endmodule
